// File: hdl/u16u8_pkg.sv
// u16u8_pkg: shared types, constants and byte-building helpers for the
// utf-16 to utf-8 transcoder; used by the front, queue and back modules
`default_nettype none

package u16u8_pkg;

    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] MASK_ONE   = 16'hFF80;
    localparam logic [15:0] MASK_TWO   = 16'hF800;
    localparam logic [15:0] MASK_SUR   = 16'hFC00;
    localparam logic [15:0] HIGH_BASE  = 16'hD800;
    localparam logic [15:0] LOW_BASE   = 16'hDC00;
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
    localparam logic [7:0]  CONT       = 8'h80;
    localparam logic [7:0]  CONT_MASK  = 8'h3F;
    localparam logic [10:0] PLANE_ADD  = 11'd64;

    typedef logic [7:0] t_byte;

    // one accepted unit's worth of output bytes, first byte at index 0
    typedef struct packed {
        t_byte [MAX_BYTES-1:0] bytes;
        logic  [CNT_W-1:0]     cnt;
        logic                  is_end;
    } t_rec;

    typedef t_byte [2:0] t_three;

    function automatic t_byte cont_byte(input logic [5:0] bits);
        cont_byte = CONT | ({2'b00, bits} & CONT_MASK);
    endfunction

    function automatic t_three three_bytes(input logic [15:0] u);
        t_three res;
        res[0] = LEAD_THREE | {4'h0, u[15:12]};
        res[1] = cont_byte(u[11:6]);
        res[2] = cont_byte(u[5:0]);
        three_bytes = res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/u16u8_front.sv
// u16u8_front: accepts code units, tracks the held high surrogate and builds
// the byte record for each unit; uses u16u8_pkg
`default_nettype none

module u16u8_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [15:0]       i_code_unit,
    output u16u8_pkg::t_rec        o_rec,
    output logic                   o_rec_valid
);

    logic [15:0]           r_held;
    logic                  r_held_valid;
    logic [15:0]           n_held;
    logic                  n_held_valid;

    logic                  is_low;
    logic                  is_high;
    logic                  pair;
    u16u8_pkg::t_three     cur_b;
    logic [1:0]            cur_n;
    u16u8_pkg::t_three     flush_b;
    logic [10:0]           plane;
    logic [20:0]           cp;
    u16u8_pkg::t_rec       rec;

    always_comb begin
        is_low  = (i_code_unit & u16u8_pkg::MASK_SUR) == u16u8_pkg::LOW_BASE;
        is_high = (i_code_unit & u16u8_pkg::MASK_SUR) == u16u8_pkg::HIGH_BASE;
        pair    = r_held_valid && is_low;
        flush_b = u16u8_pkg::three_bytes(r_held);
        // code point of the pair: plane bits from the high unit, offset by 0x10000
        plane   = {1'b0, r_held[9:0]} + u16u8_pkg::PLANE_ADD;
        cp      = {plane, i_code_unit[9:0]};

        cur_b = '0;
        cur_n = 2'd0;
        if (i_code_unit == 16'h0000) begin
            cur_n = 2'd1;
        end else if ((i_code_unit & u16u8_pkg::MASK_ONE) == 16'h0000) begin
            cur_b[0] = i_code_unit[7:0];
            cur_n    = 2'd1;
        end else if ((i_code_unit & u16u8_pkg::MASK_TWO) == 16'h0000) begin
            cur_b[0] = u16u8_pkg::LEAD_TWO | {3'b000, i_code_unit[10:6]};
            cur_b[1] = u16u8_pkg::cont_byte(i_code_unit[5:0]);
            cur_n    = 2'd2;
        end else if (is_high) begin
            cur_n = 2'd0;
        end else begin
            cur_b = u16u8_pkg::three_bytes(i_code_unit);
            cur_n = 2'd3;
        end

        rec        = '0;
        rec.is_end = (i_code_unit == 16'h0000) && !pair;
        if (pair) begin
            rec.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'b00000, cp[20:18]};
            rec.bytes[1] = u16u8_pkg::cont_byte(cp[17:12]);
            rec.bytes[2] = u16u8_pkg::cont_byte(cp[11:6]);
            rec.bytes[3] = u16u8_pkg::cont_byte(cp[5:0]);
            rec.cnt      = u16u8_pkg::CNT_W'(4);
        end else if (r_held_valid) begin
            rec.bytes[0] = flush_b[0];
            rec.bytes[1] = flush_b[1];
            rec.bytes[2] = flush_b[2];
            rec.bytes[3] = cur_b[0];
            rec.bytes[4] = cur_b[1];
            rec.bytes[5] = cur_b[2];
            rec.cnt      = u16u8_pkg::CNT_W'(3) + u16u8_pkg::CNT_W'(cur_n);
        end else begin
            rec.bytes[0] = cur_b[0];
            rec.bytes[1] = cur_b[1];
            rec.bytes[2] = cur_b[2];
            rec.cnt      = u16u8_pkg::CNT_W'(cur_n);
        end
    end

    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        if (i_accept) begin
            if (!pair && is_high) begin
                n_held       = i_code_unit;
                n_held_valid = 1'b1;
            end else begin
                n_held       = 16'h0000;
                n_held_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 16'h0000;
            r_held_valid <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

    assign o_rec       = rec;
    // a held high surrogate alone makes no bytes and queues nothing
    assign o_rec_valid = i_accept && (rec.cnt != '0);

endmodule

`default_nettype wire

// File: hdl/u16u8_fifo.sv
// u16u8_fifo: short queue of byte records between front and back
// uses u16u8_pkg for the record type and depth
`default_nettype none

module u16u8_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire u16u8_pkg::t_rec  i_wdata,
    input  wire logic             i_rd,
    output u16u8_pkg::t_rec       o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    u16u8_pkg::t_rec                  r_mem [u16u8_pkg::Q_DEPTH];
    logic [u16u8_pkg::Q_PTR_W-1:0]    r_wptr;
    logic [u16u8_pkg::Q_PTR_W-1:0]    r_rptr;
    logic [u16u8_pkg::Q_CNT_W-1:0]    r_cnt;
    logic [u16u8_pkg::Q_PTR_W-1:0]    n_wptr;
    logic [u16u8_pkg::Q_PTR_W-1:0]    n_rptr;
    logic [u16u8_pkg::Q_CNT_W-1:0]    n_cnt;
    logic                             do_wr;
    logic                             do_rd;

    assign o_full  = r_cnt == u16u8_pkg::Q_CNT_W'(u16u8_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_wr) begin
            n_wptr = (r_wptr == u16u8_pkg::Q_PTR_W'(u16u8_pkg::Q_DEPTH - 1))
                   ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == u16u8_pkg::Q_PTR_W'(u16u8_pkg::Q_DEPTH - 1))
                   ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: hdl/u16u8_back.sv
// u16u8_back: takes byte records from the queue and hands out one byte per
// pop with its run_last and text_end flags; uses u16u8_pkg
`default_nettype none

module u16u8_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire u16u8_pkg::t_rec  i_rec,
    input  wire logic             i_rec_empty,
    output logic                  o_rec_rd,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last,
    output logic                  o_text_end
);

    u16u8_pkg::t_rec                r_rec;
    logic                           r_valid;
    logic [u16u8_pkg::IDX_W-1:0]    r_idx;
    u16u8_pkg::t_rec                n_rec;
    logic                           n_valid;
    logic [u16u8_pkg::IDX_W-1:0]    n_idx;
    logic                           last;
    logic                           take;

    assign last = u16u8_pkg::CNT_W'(r_idx) == (r_rec.cnt - 1'b1);

    always_comb begin
        n_rec    = r_rec;
        n_valid  = r_valid;
        n_idx    = r_idx;
        o_rec_rd = 1'b0;
        take     = r_valid && i_pop;
        if (take && !last) begin
            n_idx = r_idx + 1'b1;
        end else if (!r_valid || take) begin
            // current record done or none held: load the next one at once
            o_rec_rd = !i_rec_empty;
            n_valid  = !i_rec_empty;
            n_rec    = i_rec;
            n_idx    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_rec.bytes[r_idx];
    assign o_run_last = last;
    assign o_text_end = last && r_rec.is_end;

endmodule

`default_nettype wire

// File: hdl/utf16_to_utf8_transcoder.sv
// utf16_to_utf8_transcoder: top level joining front, record queue and back
// depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back
//
// Takes one UTF-16 code unit per push and pops UTF-8 bytes one at a time, in
// order. A unit is accepted in any cycle in which full is low; each unit
// makes from zero bytes (a held high surrogate) up to six bytes (a held unit
// flushed ahead of a three-byte unit). Sustained throughput is one output byte per
// cycle while pop is held and records are queued, set by the back end that
// shifts out one byte of a record per pop. A two-entry record queue between
// the front and the back lets input keep flowing while the output side
// stalls, until the queue fills. run_last marks the final byte of each
// accepted unit's record; text_end marks the 0x00 byte made by a zero unit.
`default_nettype none

module utf16_to_utf8_transcoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_code_unit,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_text_end
);

    u16u8_pkg::t_rec  front_rec;
    logic             front_rec_valid;
    u16u8_pkg::t_rec  q_rec;
    logic             q_full;
    logic             q_empty;
    logic             q_rd;
    logic             accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_unit (i_code_unit),
        .o_rec       (front_rec),
        .o_rec_valid (front_rec_valid)
    );

    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_rec_valid),
        .i_wdata (front_rec),
        .i_rd    (q_rd),
        .o_rdata (q_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (q_rec),
        .i_rec_empty (q_empty),
        .o_rec_rd    (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_end  (o_text_end)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking testbench for the utf-16 to utf-8 transcoder
// depends on u16u8_pkg for the mask constants and on the utf16_to_utf8_transcoder rtl
`timescale 1ns / 1ps

class utf8_scoreboard;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } utf8_byte_t;

    utf8_byte_t  expected_bytes[$];
    utf8_byte_t  run_bytes[$];
    logic [15:0] held_unit;
    bit          held_flag;
    int          mismatches;

    function new();
        held_unit  = '0;
        held_flag  = 1'b0;
        mismatches = 0;
    endfunction

    function void add_byte(logic [7:0] b, logic tend);
        utf8_byte_t e;
        e.out_byte = b;
        e.run_last = 1'b0;
        e.text_end = tend;
        run_bytes.push_back(e);
    endfunction

    function void add_three(logic [15:0] u);
        add_byte({4'b1110, u[15:12]}, 1'b0);
        add_byte({2'b10, u[11:6]}, 1'b0);
        add_byte({2'b10, u[5:0]}, 1'b0);
    endfunction

    // the last byte of a request carries run_last
    function void close_run();
        if (run_bytes.size() > 0) begin
            run_bytes[run_bytes.size() - 1].run_last = 1'b1;
        end
        foreach (run_bytes[i]) begin
            expected_bytes.push_back(run_bytes[i]);
        end
        run_bytes.delete();
    endfunction

    function void note_unit(logic [15:0] u);
        logic [20:0] cp;
        run_bytes.delete();
        if (held_flag) begin
            held_flag = 1'b0;
            if ((u & u16u8_pkg::MASK_SUR) == u16u8_pkg::LOW_BASE) begin
                cp = 21'h10000 + (21'(held_unit - u16u8_pkg::HIGH_BASE) << 10)
                     + 21'(u - u16u8_pkg::LOW_BASE);
                add_byte({5'b11110, cp[20:18]}, 1'b0);
                add_byte({2'b10, cp[17:12]}, 1'b0);
                add_byte({2'b10, cp[11:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
                close_run();
                return;
            end
            // held unit without its low half goes out as a plain three-byte pattern
            add_three(held_unit);
        end
        if (u == 16'h0000) begin
            add_byte(8'h00, 1'b1);
        end else if ((u & u16u8_pkg::MASK_ONE) == 16'h0000) begin
            add_byte(u[7:0], 1'b0);
        end else if ((u & u16u8_pkg::MASK_TWO) == 16'h0000) begin
            add_byte({3'b110, u[10:6]}, 1'b0);
            add_byte({2'b10, u[5:0]}, 1'b0);
        end else if ((u & u16u8_pkg::MASK_SUR) == u16u8_pkg::HIGH_BASE) begin
            held_unit = u;
            held_flag = 1'b1;
        end else begin
            add_three(u);
        end
        close_run();
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic tend);
        utf8_byte_t e;
        if (expected_bytes.size() == 0) begin
            $error("unexpected byte %h (run_last %b, text_end %b)", b, last, tend);
            mismatches++;
            return;
        end
        e = expected_bytes.pop_front();
        if (b !== e.out_byte) begin
            $error("out_byte: expected %h, got %h", e.out_byte, b);
            mismatches++;
        end
        if (last !== e.run_last) begin
            $error("run_last: expected %b, got %b", e.run_last, last);
            mismatches++;
        end
        if (tend !== e.text_end) begin
            $error("text_end: expected %b, got %b", e.text_end, tend);
            mismatches++;
        end
    endfunction

endclass

module tb_top;

    localparam int UNIT_TARGET = 310;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [15:0] i_code_unit = '0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_text_end;

    utf8_scoreboard sb = new();
    int  units_sent = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    utf16_to_utf8_transcoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_code_unit(i_code_unit),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_text_end (o_text_end)
    );

    always #10 i_clk = ~i_clk;

    task automatic send_unit(input logic [15:0] u);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_code_unit <= u;
        do @(posedge i_clk); while (full);
        sb.note_unit(u);
        units_sent++;
    endtask

    function automatic logic [15:0] pick_bmp_three();
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(16'h0800, 16'hD7FF));
        return 16'($urandom_range(16'hE000, 16'hFFFF));
    endfunction

    task automatic send_random();
        case ($urandom_range(0, 15))
            0, 1, 2, 3: send_unit(16'($urandom_range(1, 16'h007F)));
            4, 5:       send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
            6, 7:       send_unit(pick_bmp_three());
            8, 9, 10: begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            11:         send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            12:         send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            13:         send_unit(16'h0000);
            default:    send_unit(16'($urandom_range(0, 16'hFFFF)));
        endcase
    endtask

    // result side: random stall before each pop request
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_byte(o_out_byte, o_run_last, o_text_end);
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range edges, pairs, flushes and terminators
        send_unit(16'h0000);
        send_unit(16'h0001);
        send_unit(16'h007F);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hD7FF);
        send_unit(16'hE000);
        send_unit(16'hFFFF);
        send_unit(16'hD800);
        send_unit(16'hDC00);
        send_unit(16'hDBFF);
        send_unit(16'hDFFF);
        send_unit(16'hDC00);
        send_unit(16'hD800);
        send_unit(16'h0041);
        send_unit(16'hDBFF);
        send_unit(16'hD800);
        send_unit(16'hDFFF);
        send_unit(16'hD801);
        send_unit(16'h0000);
        send_unit(16'hDA55);
        send_unit(16'hFFFF);
        send_unit(16'hDAAA);
        send_unit(16'h07FF);

        while (units_sent < UNIT_TARGET) send_random();
        push <= 1'b0;

        while (sb.expected_bytes.size() > 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
